// File: hw/rtl/srts_pkg.sv
// ----------------------------------------------------------------------------
// srts_pkg: shared types and constants of the scheduler
// Entry, request and result formats, table commands, result codes.
// ----------------------------------------------------------------------------
package srts_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // load target carried in proc_status
    localparam logic LOAD_TO_READY = 1'b0;
    localparam logic LOAD_TO_WAIT  = 1'b1;

    // destination codes
    localparam logic [1:0] DEST_NONE  = 2'd0;
    localparam logic [1:0] DEST_DONE  = 2'd1;
    localparam logic [1:0] DEST_WAIT  = 2'd2;
    localparam logic [1:0] DEST_READY = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [3:0]           id;
        logic [3:0]           prio;
        logic [TIME_BITS-1:0] time_left;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op op;
        t_entry  entry;
    } t_tbl_cmd;

    typedef struct packed {
        logic   full;
        logic   empty;
        t_entry head;
    } t_tbl_stat;

    typedef struct packed {
        logic       func;
        logic [3:0] proc_id;
        logic       proc_status;
        logic [3:0] proc_priority;
        logic [7:0] run_time;
        logic       wake_request;
        logic [7:0] slice_length;
        logic       send_to_wait;
    } t_in;

    typedef struct packed {
        logic       woken_valid;
        logic [3:0] woken_id;
        logic       ran_valid;
        logic [3:0] ran_id;
        logic [3:0] ran_priority;
        logic [7:0] remaining_time;
        logic [1:0] destination;
        logic [1:0] error_code;
    } t_out;

endpackage

// File: hw/rtl/shortest_remaining_time_scheduler_top.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_top: shortest-remaining-time scheduler
// Ready and wait tables as sorted cell chains, driven by a step sequencer.
// ----------------------------------------------------------------------------
// The block holds two tables of up to QUEUE_DEPTH processes, each kept in
// ascending order of remaining time with a newly inserted entry placed ahead
// of entries of equal time. A load request inserts one process; a step
// request optionally wakes the wait head into the ready table, runs the ready
// head for one slice, and finishes or reinserts it. Every request returns
// exactly one result. One request is handled at a time: the sequencer
// issues its table operations to the cell chains in order (load insert, or
// wake, run pop and reinsert, with no reinsert when the process finishes or
// the ready table is empty), then loads the result register. The result
// register lets a new request be accepted while the previous result is
// still stalled; a finished request waits in its last state only until
// that register frees up.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  srts_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output srts_pkg::t_out o_out_data
);
    import srts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WAKE,
        S_RUN,
        S_REINS,
        S_DONE
    } t_state;

    t_state    r_state;
    t_in       r_req;      // request under work
    t_out      r_res;      // result being built
    t_out      r_out;      // result offered downstream
    logic      r_out_valid;
    t_entry    r_run;      // process that ran, with its new time

    t_tbl_cmd  w_rdy_cmd;
    t_tbl_cmd  w_wt_cmd;
    t_tbl_stat w_rdy;
    t_tbl_stat w_wt;
    t_entry    w_load;
    logic [TIME_BITS-1:0] w_slice;
    logic      w_wake_go;
    logic      w_out_load;

    // times are kept to TIME_BITS bits
    assign w_load.id        = r_req.proc_id;
    assign w_load.prio      = r_req.proc_priority;
    assign w_load.time_left = TIME_BITS'(r_req.run_time);
    assign w_slice          = TIME_BITS'(r_req.slice_length);

    // wake happens only with something waiting and room in the ready table
    assign w_wake_go = r_req.wake_request && !w_wt.empty && !w_rdy.full;

    // hand the finished result over once the result register is free
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // table commands for the current sequencer state
    always_comb begin
        w_rdy_cmd.op    = OP_HOLD;
        w_rdy_cmd.entry = w_load;
        w_wt_cmd.op     = OP_HOLD;
        w_wt_cmd.entry  = w_load;
        case (r_state)
            S_LOAD: begin
                if (r_req.proc_status == LOAD_TO_READY) begin
                    w_rdy_cmd.op = OP_INSERT;
                end else begin
                    w_wt_cmd.op = OP_INSERT;
                end
            end
            S_WAKE: begin
                // move the wait head straight into the ready chain
                if (w_wake_go) begin
                    w_wt_cmd.op     = OP_POP;
                    w_rdy_cmd.op    = OP_INSERT;
                    w_rdy_cmd.entry = w_wt.head;
                end
            end
            S_RUN: begin
                w_rdy_cmd.op = OP_POP;
            end
            S_REINS: begin
                // a full wait table sends the process back to ready
                w_rdy_cmd.entry = r_run;
                w_wt_cmd.entry  = r_run;
                if (r_req.send_to_wait && !w_wt.full) begin
                    w_wt_cmd.op = OP_INSERT;
                end else begin
                    w_rdy_cmd.op = OP_INSERT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // offer a new result, or drop the offered one once taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_res   <= '0;
                        r_state <= (i_in_data.func == FUNC_STEP) ? S_WAKE : S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_req.proc_status == LOAD_TO_READY ? w_rdy.full : w_wt.full) begin
                        r_res.error_code <= ERR_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_WAKE: begin
                    if (w_wake_go) begin
                        r_res.woken_valid <= 1'b1;
                        r_res.woken_id    <= w_wt.head.id;
                    end else if (r_req.wake_request && !w_wt.empty) begin
                        r_res.error_code <= ERR_FULL;
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_rdy.empty) begin
                        r_res.error_code <= ERR_EMPTY;
                        r_state          <= S_DONE;
                    end else begin
                        r_res.ran_valid    <= 1'b1;
                        r_res.ran_id       <= w_rdy.head.id;
                        r_res.ran_priority <= w_rdy.head.prio;
                        if (w_rdy.head.time_left <= w_slice) begin
                            r_res.remaining_time <= '0;
                            r_res.destination    <= DEST_DONE;
                            r_state              <= S_DONE;
                        end else begin
                            r_run.id             <= w_rdy.head.id;
                            r_run.prio           <= w_rdy.head.prio;
                            r_run.time_left      <= w_rdy.head.time_left - w_slice;
                            r_res.remaining_time <= 8'(w_rdy.head.time_left - w_slice);
                            r_state              <= S_REINS;
                        end
                    end
                end
                S_REINS: begin
                    if (r_req.send_to_wait && !w_wt.full) begin
                        r_res.destination <= DEST_WAIT;
                    end else begin
                        r_res.destination <= DEST_READY;
                        if (r_req.send_to_wait) begin
                            r_res.error_code <= ERR_FULL;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (w_out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    srts_table u_ready (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_rdy_cmd),
        .o_stat  (w_rdy)
    );

    srts_table u_wait (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_wt_cmd),
        .o_stat  (w_wt)
    );

endmodule

// File: hw/rtl/srts_cell.sv
// ----------------------------------------------------------------------------
// srts_cell: one slot of a sorted table
// Holds one entry; on insert shifts right or captures the new entry,
// on pop takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
module srts_cell (
    input  logic            i_clk,
    input  srts_pkg::t_tbl_op i_op,
    input  srts_pkg::t_entry  i_new,
    input  srts_pkg::t_entry  i_left,
    input  logic            i_left_disp,
    input  srts_pkg::t_entry  i_right,
    input  logic            i_occupied,
    input  logic            i_at_end,
    output srts_pkg::t_entry  o_entry,
    output logic            o_disp
);
    import srts_pkg::*;

    t_entry r_entry;

    // new entry goes ahead of any entry with the same time
    assign o_disp  = i_occupied && (i_new.time_left <= r_entry.time_left);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_INSERT: begin
                if (i_left_disp) begin
                    r_entry <= i_left;
                end else if (o_disp || i_at_end) begin
                    r_entry <= i_new;
                end
            end
            OP_POP: begin
                r_entry <= i_right;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/srts_table.sv
// ----------------------------------------------------------------------------
// srts_table: sorted table built from a chain of cells
// Keeps the fill count; entries at or above the count are don't-care.
// ----------------------------------------------------------------------------
module srts_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srts_pkg::t_tbl_cmd  i_cmd,
    output srts_pkg::t_tbl_stat o_stat
);
    import srts_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic             w_full;
    logic             w_empty;
    t_tbl_op          w_op;
    t_entry           w_entry [QUEUE_DEPTH];
    logic             w_disp  [QUEUE_DEPTH];
    t_entry           w_left  [QUEUE_DEPTH];
    t_entry           w_right [QUEUE_DEPTH];
    logic             w_ldisp [QUEUE_DEPTH];

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    // drop operations the table cannot take
    always_comb begin
        w_op = i_cmd.op;
        if ((i_cmd.op == OP_INSERT && w_full) || (i_cmd.op == OP_POP && w_empty)) begin
            w_op = OP_HOLD;
        end
    end

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (k == 0) begin
                w_left[k]  = '0;
                w_ldisp[k] = 1'b0;
            end else begin
                w_left[k]  = w_entry[k-1];
                w_ldisp[k] = w_disp[k-1];
            end
            if (k == QUEUE_DEPTH - 1) begin
                w_right[k] = '0;
            end else begin
                w_right[k] = w_entry[k+1];
            end
        end
    end

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        srts_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_new       (i_cmd.entry),
            .i_left      (w_left[gi]),
            .i_left_disp (w_ldisp[gi]),
            .i_right     (w_right[gi]),
            .i_occupied  (CNT_W'(gi) < r_count),
            .i_at_end    (CNT_W'(gi) == r_count),
            .o_entry     (w_entry[gi]),
            .o_disp      (w_disp[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (w_op)
                OP_INSERT: r_count <= r_count + CNT_W'(1);
                OP_POP:    r_count <= r_count - CNT_W'(1);
                default:   r_count <= r_count;
            endcase
        end
    end

    assign o_stat.full  = w_full;
    assign o_stat.empty = w_empty;
    assign o_stat.head  = w_entry[0];

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("table count above depth");

    a_insert_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op == OP_INSERT |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow table");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op == OP_POP |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not shrink table");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> w_entry[0].time_left <= w_entry[1].time_left)
        else $error("table head out of order");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: request-level check of the shortest-remaining-time scheduler
// Drives load and step requests through the valid/stall request channel,
// predicts each result with a queue-based model of the ready and wait tables,
// and compares every result field by field under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import srts_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int ITEMS_PER_MIX  = 260;

    // one process as the tables hold it
    typedef struct packed {
        logic [3:0]           id;
        logic [3:0]           prio;
        logic [TIME_BITS-1:0] tleft;
    } sched_proc_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // predicted table contents, ordered by ascending remaining time
    sched_proc_t ready_procs[$];
    sched_proc_t waiting_procs[$];
    // results predicted for requests already driven, oldest first
    t_out        pending_results[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_woken    = 0;
    int n_finished = 0;
    int n_full     = 0;
    int n_empty    = 0;

    shortest_remaining_time_scheduler_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scheduler prediction
    // ------------------------------------------------------------------------

    // Find the slot for a new entry: ahead of every entry with the same time.
    function automatic int slot_for(sched_proc_t tbl[$], logic [TIME_BITS-1:0] tleft);
        int pos = 0;
        while (pos < tbl.size() && tbl[pos].tleft < tleft) pos++;
        return pos;
    endfunction

    // Apply one request to the predicted tables and return the result it yields.
    function automatic t_out predict_result(t_in req);
        t_out        res;
        sched_proc_t p;
        res = '0;
        if (req.func == FUNC_LOAD) begin
            // a load reports nothing but a possible full-table error
            p = '{id: req.proc_id, prio: req.proc_priority, tleft: req.run_time};
            if (req.proc_status == LOAD_TO_READY) begin
                if (ready_procs.size() < QUEUE_DEPTH)
                    ready_procs.insert(slot_for(ready_procs, p.tleft), p);
                else
                    res.error_code = ERR_FULL;
            end else begin
                if (waiting_procs.size() < QUEUE_DEPTH)
                    waiting_procs.insert(slot_for(waiting_procs, p.tleft), p);
                else
                    res.error_code = ERR_FULL;
            end
        end else begin
            // wake first; a full ready table blocks it but the run goes on
            if (req.wake_request && waiting_procs.size() > 0) begin
                if (ready_procs.size() < QUEUE_DEPTH) begin
                    p = waiting_procs.pop_front();
                    ready_procs.insert(slot_for(ready_procs, p.tleft), p);
                    res.woken_valid = 1'b1;
                    res.woken_id    = p.id;
                end else begin
                    res.error_code = ERR_FULL;
                end
            end
            if (ready_procs.size() == 0) begin
                res.error_code = ERR_EMPTY;
            end else begin
                p = ready_procs.pop_front();
                res.ran_valid    = 1'b1;
                res.ran_id       = p.id;
                res.ran_priority = p.prio;
                if (p.tleft <= req.slice_length) begin
                    res.destination = DEST_DONE;
                end else begin
                    p.tleft            = p.tleft - req.slice_length;
                    res.remaining_time = p.tleft;
                    if (req.send_to_wait && waiting_procs.size() < QUEUE_DEPTH) begin
                        waiting_procs.insert(slot_for(waiting_procs, p.tleft), p);
                        res.destination = DEST_WAIT;
                    end else begin
                        // full wait table falls back to ready, which just freed a slot
                        if (req.send_to_wait) res.error_code = ERR_FULL;
                        ready_procs.insert(slot_for(ready_procs, p.tleft), p);
                        res.destination = DEST_READY;
                    end
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request building
    // ------------------------------------------------------------------------

    function automatic t_in random_bits();
        logic [31:0] r;
        r = $urandom();
        return r[$bits(t_in)-1:0];
    endfunction

    // Build a load; fields a load ignores stay random.
    function automatic t_in load_req(logic [3:0] id, logic [3:0] prio, logic target,
                                     logic [7:0] run_len);
        t_in req;
        req               = random_bits();
        req.func          = FUNC_LOAD;
        req.proc_id       = id;
        req.proc_priority = prio;
        req.proc_status   = target;
        req.run_time      = run_len;
        return req;
    endfunction

    // Build a step; fields a step ignores stay random.
    function automatic t_in step_req(logic wake, logic [7:0] slice, logic to_wait);
        t_in req;
        req              = random_bits();
        req.func         = FUNC_STEP;
        req.wake_request = wake;
        req.slice_length = slice;
        req.send_to_wait = to_wait;
        return req;
    endfunction

    // Steer most requests toward a busy but not saturated pair of tables; leave
    // one in ten fully random as noise.
    function automatic t_in random_request();
        t_in req;
        int  occupancy;
        int  load_pct;
        req       = random_bits();
        occupancy = ready_procs.size() + waiting_procs.size();
        load_pct  = (occupancy < 6) ? 70 : (occupancy > 26) ? 25 : 50;
        if ($urandom_range(99) >= 10) begin
            req.func = ($urandom_range(99) < load_pct) ? FUNC_LOAD : FUNC_STEP;
            // short slices keep processes cycling between the tables
            if ($urandom_range(3) != 0) req.slice_length = 8'($urandom_range(0, 40));
            // short run times make ties common
            if ($urandom_range(3) == 0) req.run_time = 8'($urandom_range(0, 8));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Request channel
    // ------------------------------------------------------------------------

    // Send one request. Call at a falling edge; return at a falling edge with
    // valid still high so that back-to-back requests need no gap.
    task automatic send_request(t_in req);
        // idle a random number of cycles, with junk on the data lines
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            in_data  <= random_bits();
            @(negedge clk);
        end
        // predict now: requests are accepted strictly in the order sent
        pending_results.push_back(predict_result(req));
        n_sent++;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------------

    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            n_errors++;
        end
    endtask

    // Check every accepted result against the oldest prediction.
    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, got %h",
                         $time, out_data);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                compare_field("woken_valid", 8'(want.woken_valid),
                              8'(out_data.woken_valid));
                compare_field("woken_id", 8'(want.woken_id), 8'(out_data.woken_id));
                compare_field("ran_valid", 8'(want.ran_valid), 8'(out_data.ran_valid));
                compare_field("ran_id", 8'(want.ran_id), 8'(out_data.ran_id));
                compare_field("ran_priority", 8'(want.ran_priority),
                              8'(out_data.ran_priority));
                compare_field("remaining_time", want.remaining_time,
                              out_data.remaining_time);
                compare_field("destination", 8'(want.destination),
                              8'(out_data.destination));
                compare_field("error_code", 8'(want.error_code), 8'(out_data.error_code));
                n_woken    += int'(want.woken_valid);
                n_finished += int'(want.destination == DEST_DONE);
                n_full     += int'(want.error_code == ERR_FULL);
                n_empty    += int'(want.error_code == ERR_EMPTY);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk the basic behaviors with hand-picked fields and no idling.
    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // step with both tables empty: nothing to wake, nothing to run
        send_request(step_req(1'b1, 8'd0, 1'b0));
        // zero run time with zero slice still finishes
        send_request(load_req(4'd0, 4'd0, LOAD_TO_READY, 8'd0));
        send_request(step_req(1'b0, 8'd0, 1'b1));
        // equal times: the later load goes ahead
        send_request(load_req(4'd15, 4'd15, LOAD_TO_READY, 8'd255));
        send_request(load_req(4'd3, 4'd9, LOAD_TO_READY, 8'd255));
        send_request(load_req(4'd5, 4'd1, LOAD_TO_WAIT, 8'd100));
        send_request(load_req(4'd6, 4'd2, LOAD_TO_WAIT, 8'd100));
        // wake the wait head, run it for one slice, park it back in wait
        send_request(step_req(1'b1, 8'd1, 1'b1));
        // run the tied head, requeue it into ready
        send_request(step_req(1'b0, 8'd254, 1'b0));
        // a slice longer than the remaining run time finishes the process
        send_request(step_req(1'b1, 8'd255, 1'b1));
        send_request(step_req(1'b0, 8'd98, 1'b0));
        send_request(step_req(1'b1, 8'd0, 1'b1));
        send_request(load_req(4'd15, 4'd15, LOAD_TO_WAIT, 8'd255));
        send_request(load_req(4'd10, 4'd5, LOAD_TO_READY, 8'd1));
        // empty both tables with full slices, then step on the empty ready table
        repeat (6) send_request(step_req(1'b1, 8'd255, 1'b0));
        send_request(step_req(1'b0, 8'd17, 1'b1));
    endtask

    // Overflow both tables and the wake and reinsert paths that depend on room.
    task automatic test_full_tables();
        sender_idle_pct    = 29;
        receiver_stall_pct = 29;
        // fill ready and push one past its depth
        repeat (QUEUE_DEPTH + 1 - ready_procs.size())
            send_request(load_req(4'($urandom), 4'($urandom), LOAD_TO_READY,
                                  8'($urandom_range(1, 255))));
        send_request(load_req(4'($urandom), 4'($urandom), LOAD_TO_WAIT, 8'($urandom)));
        // wake blocked by the full ready table; zero slice forces a reinsert
        send_request(step_req(1'b1, 8'd0, 1'b0));
        send_request(step_req(1'b1, 8'd0, 1'b1));
        // fill wait and push one past its depth
        repeat (QUEUE_DEPTH + 1 - waiting_procs.size())
            send_request(load_req(4'($urandom), 4'($urandom), LOAD_TO_WAIT,
                                  8'($urandom)));
        // reinsert aimed at the full wait table lands in ready
        repeat (3) send_request(step_req(1'b0, 8'd0, 1'b1));
        // drain everything: each full slice finishes one process
        while (ready_procs.size() + waiting_procs.size() > 0)
            send_request(step_req(1'b1, 8'd255, 1'($urandom)));
    endtask

    task automatic run_random_mix(int n_items, bit pause_midway);
        for (int k = 0; k < n_items; k++) begin
            if (pause_midway && k == n_items / 2) drain_results();
            send_request(random_request());
        end
    endtask

    task automatic test_no_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_mix(ITEMS_PER_MIX, 1'b1);
    endtask

    task automatic test_sender_idle();
        sender_idle_pct    = 65;
        receiver_stall_pct = 0;
        run_random_mix(ITEMS_PER_MIX, 1'b0);
    endtask

    task automatic test_receiver_stall();
        sender_idle_pct    = 0;
        receiver_stall_pct = 65;
        run_random_mix(ITEMS_PER_MIX, 1'b0);
    endtask

    task automatic test_both_idle();
        sender_idle_pct    = 29;
        receiver_stall_pct = 29;
        run_random_mix(ITEMS_PER_MIX, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        // hold reset, release it on a falling edge
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_tables();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        // let every result come back, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("summary: %0d requests sent, %0d results checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("summary: %0d wakes, %0d finishes, %0d table-full and %0d empty-table errors",
                 n_woken, n_finished, n_full, n_empty);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results still pending", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
